/* sv/assert_macros.svh */
// assertion helpers used by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tfsf_pkg.sv */
// ----------------------------------------------------------------------------
// tfsf_pkg
// Constants, register codes and tag tables for the tagged record filter.
// ----------------------------------------------------------------------------
package tfsf_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 32;
  localparam int PATTERN_STORE_BYTES   = 32;
  localparam int CFG_ADDR_W            = 6;
  localparam int CFG_DATA_W            = 64;
  localparam int LEN_W                 = 6;
  localparam int COUNT_W               = 32;

  localparam logic [2:0] TITLE_TAG_LEN = 3'd7;
  localparam logic [2:0] TEXT_TAG_LEN  = 3'd5;

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;

  // configuration register codes, one per 8-byte slot
  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_BYTES_0_7      = 3'd1,
    REG_BYTES_8_15     = 3'd2,
    REG_BYTES_16_23    = 3'd3,
    REG_BYTES_24_31    = 3'd4
  } cfg_reg_t;

  // expected character at each place of "<title>"
  function automatic logic [7:0] title_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h3C;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h6C;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // expected character at each place of "<text"
  function automatic logic [7:0] text_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h3C;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h78;
      3'd4:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* sv/tagged_record_fixed_string_filter.sv */
// Tagged record filter: takes one markup byte per item and, on the '<' that
// closes each text body, delivers one item telling whether the configured
// pattern lay wholly inside that body, with the running title count. One byte
// is taken every cycle while the input is not held off; a byte waits in the input
// register and its result is registered in the output register. The rate is
// kept by the combinational window compare of the newest body bytes against the
// pattern, pre-aligned to the configured length.
// Input is held off only while a finished result waits and the byte in the
// input register would produce another one. No clearing pass after reset.

// ----------------------------------------------------------------------------
// tagged_record_fixed_string_filter
// Tag tracker, body byte window and fixed pattern compare with apb setup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tagged_record_fixed_string_filter #(
  parameter int MAX_PATTERN_BYTES = tfsf_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_stream_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_body_matched,
  output logic [tfsf_pkg::COUNT_W-1:0]   out_article_number,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tfsf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tfsf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tfsf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import tfsf_pkg::*;

  localparam int P      = MAX_PATTERN_BYTES;
  localparam int FILL_W = $clog2(P + 1);

  typedef enum logic [1:0] {
    PH_TITLE = 2'd0,
    PH_TEXT  = 2'd1,
    PH_GT    = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

  // configuration registers
  logic [LEN_W-1:0]      pat_len_r;
  logic [CFG_DATA_W-1:0] pat_words_r [4];
  logic                  cfg_wr;
  cfg_reg_t              cfg_sel;

  // pattern aligned to window order
  logic [7:0]            pat_al_r  [P];
  logic [7:0]            pat_al_nxt[P];
  logic [P-1:0]          pat_use_r;
  logic [P-1:0]          pat_use_nxt;

  // input register
  logic                  in_valid_r;
  logic [7:0]            in_byte_r;

  // scan state
  phase_t                phase_r, phase_nxt;
  logic [2:0]            prog_r, prog_nxt;
  logic [7:0]            win_r  [P];
  logic [7:0]            win_nxt[P];
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  found_r, found_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;

  // output register
  logic                  out_valid_r;
  logic                  out_matched_r;
  logic [COUNT_W-1:0]    out_number_r;

  logic                  emit;
  logic                  advance;
  logic                  in_accept;
  logic                  window_hit;
  logic [P-1:0]          byte_ok;

  // apb decode
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[5:3]);

  always_comb begin
    case (cfg_sel)
      REG_PATTERN_LENGTH: cfg_prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pat_len_r};
      REG_BYTES_0_7:      cfg_prdata = pat_words_r[0];
      REG_BYTES_8_15:     cfg_prdata = pat_words_r[1];
      REG_BYTES_16_23:    cfg_prdata = pat_words_r[2];
      REG_BYTES_24_31:    cfg_prdata = pat_words_r[3];
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      for (int i = 0; i < 4; i++) begin
        pat_words_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_PATTERN_LENGTH: pat_len_r      <= cfg_pwdata[LEN_W-1:0];
        REG_BYTES_0_7:      pat_words_r[0] <= cfg_pwdata;
        REG_BYTES_8_15:     pat_words_r[1] <= cfg_pwdata;
        REG_BYTES_16_23:    pat_words_r[2] <= cfg_pwdata;
        REG_BYTES_24_31:    pat_words_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // window slot k must hold pattern byte len-1-k
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < P; k++) begin
      idx            = pat_len_r - LEN_W'(1) - LEN_W'(k);
      pat_al_nxt[k]  = pat_words_r[idx[4:3]][{idx[2:0], 3'b000} +: 8];
      pat_use_nxt[k] = LEN_W'(k) < pat_len_r;
    end
  end

  always_ff @(posedge clk) begin
    pat_al_r  <= pat_al_nxt;
    pat_use_r <= pat_use_nxt;
  end

  // handshake between input and output registers
  assign emit      = in_valid_r && (phase_r == PH_BODY) && (in_byte_r == CH_LT);
  assign advance   = in_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_stream_byte;
    end
  end

  // body window shifted by the current byte
  always_comb begin
    win_nxt[0] = in_byte_r;
    for (int k = 1; k < P; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // compare the shifted window against the aligned pattern
  always_comb begin
    for (int k = 0; k < P; k++) begin
      byte_ok[k] = !pat_use_r[k] || (win_nxt[k] == pat_al_r[k]);
    end
  end

  // fill after this body byte, saturation does not change the length test
  always_comb begin
    logic [FILL_W:0] fill_ext;
    logic [LEN_W:0]  len_ext;
    fill_ext   = {1'b0, fill_r} + (FILL_W+1)'(1);
    len_ext    = {1'b0, pat_len_r};
    window_hit = (pat_len_r == '0) ||
                 ((LEN_W+1)'(P) >= len_ext && (LEN_W+1)'(fill_ext) >= len_ext && &byte_ok);
  end

  // scan state next values
  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    fill_nxt  = fill_r;
    found_nxt = found_r;
    count_nxt = count_r;
    case (phase_r)
      PH_TITLE: begin
        if (prog_r < TITLE_TAG_LEN && in_byte_r == title_char(prog_r)) begin
          if (prog_r == TITLE_TAG_LEN - 3'd1) begin
            prog_nxt  = 3'd0;
            count_nxt = count_r + COUNT_W'(1);
            phase_nxt = PH_TEXT;
          end else begin
            prog_nxt = prog_r + 3'd1;
          end
        end else begin
          prog_nxt = (in_byte_r == CH_LT) ? 3'd1 : 3'd0;
        end
      end
      PH_TEXT: begin
        if (prog_r < TEXT_TAG_LEN && in_byte_r == text_char(prog_r)) begin
          if (prog_r == TEXT_TAG_LEN - 3'd1) begin
            prog_nxt  = 3'd0;
            phase_nxt = PH_GT;
          end else begin
            prog_nxt = prog_r + 3'd1;
          end
        end else begin
          prog_nxt = (in_byte_r == CH_LT) ? 3'd1 : 3'd0;
        end
      end
      PH_GT: begin
        if (in_byte_r == CH_GT) begin
          phase_nxt = PH_BODY;
          fill_nxt  = '0;
          found_nxt = 1'b0;
        end
      end
      PH_BODY: begin
        if (in_byte_r == CH_LT) begin
          phase_nxt = PH_TITLE;
          prog_nxt  = 3'd1;
        end else begin
          if (fill_r < FILL_W'(P)) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
          if (window_hit) begin
            found_nxt = 1'b1;
          end
        end
      end
      default: phase_nxt = PH_TITLE;
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TITLE;
      prog_r      <= '0;
      fill_r      <= '0;
      found_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < P; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (advance) begin
        phase_r <= phase_nxt;
        prog_r  <= prog_nxt;
        fill_r  <= fill_nxt;
        found_r <= found_nxt;
        count_r <= count_nxt;
        if (phase_r == PH_BODY && !emit) begin
          win_r <= win_nxt;
        end
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_matched_r <= found_r || (pat_len_r == '0);
      out_number_r  <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_body_matched   = out_matched_r;
  assign out_article_number = out_number_r;

  // checks
  `ASSERT_NEXT(a_emit_shows, clk, rst_n, advance && emit, out_valid,
    "result item lost on closing byte")
  `ASSERT_NEXT(a_stalled_byte_kept, clk, rst_n, in_stall,
    in_valid_r && $stable(in_byte_r), "held input byte changed")
  `ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(P),
    "body fill past window depth")
  `ASSERT_SAME(a_prog_bound, clk, rst_n, 1'b1, prog_r < TITLE_TAG_LEN,
    "tag progress out of range")

endmodule
